[design/swbs_pkg.sv]
package swbs_pkg;

    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [1:0] REG_TARGET_BATCH = 2'd1;
    localparam logic [1:0] REG_MAX_BATCH    = 2'd2;

    localparam logic [6:0]  WINDOW_SIZE_RST  = 7'd16;
    localparam logic [15:0] TARGET_BATCH_RST = 16'd0;
    localparam logic [15:0] MAX_BATCH_RST    = 16'd64;

    typedef struct packed {
        logic [15:0] wr_count;
        logic [15:0] q_depth;
        logic [31:0] batch_log_bytes;
        logic [63:0] total_reads;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  window_count;
        logic [15:0] avg_size;
        logic [9:0]  batch_fill_per_1000;
        logic [31:0] avg_log_bytes;
        logic [37:0] window_reads;
        logic [21:0] window_writes;
        logic [9:0]  read_ratio_per_1000;
        logic [15:0] peak_depth;
        logic [15:0] sync_pressure_per_1000;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic drop_rd;
        logic drop_sub;
        logic push;
        logic div_start;
        logic div_skip;
        logic div_store;
        logic scan_init;
        logic scan_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_full;
        logic over_limit;
        logic op_end;
        logic op_needed;
        logic div_done;
        logic scan_done;
        logic out_busy;
    } ctrl_status_t;

endpackage

[design/swbs_ram.sv]
module swbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/swbs_div.sv]
module swbs_div #(
    parameter int W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] quo
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = rem_sh - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[design/swbs_ctrl.sv]
module swbs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  swbs_pkg::ctrl_status_t status,
    output swbs_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DROP_RD   = 9'b000000010,
        S_DROP_SUB  = 9'b000000100,
        S_PUSH      = 9'b000001000,
        S_TRIM      = 9'b000010000,
        S_DIV_SETUP = 9'b000100000,
        S_DIV_RUN   = 9'b001000000,
        S_SCAN      = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   pushed_reg, pushed_next;

    always_comb
    begin
        state_next  = state_reg;
        pushed_next = pushed_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    pushed_next = 1'b0;
                    state_next  = status.count_full ? S_DROP_RD : S_PUSH;
                end
            end
            S_DROP_RD:
            begin
                cmd.drop_rd = 1'b1;
                state_next  = S_DROP_SUB;
            end
            S_DROP_SUB:
            begin
                cmd.drop_sub = 1'b1;
                state_next   = pushed_reg ? S_TRIM : S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push    = 1'b1;
                pushed_next = 1'b1;
                state_next  = S_TRIM;
            end
            S_TRIM:
            begin
                state_next = status.over_limit ? S_DROP_RD : S_DIV_SETUP;
            end
            S_DIV_SETUP:
            begin
                if (status.op_end)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else if (status.op_needed)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_RUN;
                end
                else
                begin
                    cmd.div_skip = 1'b1;
                end
            end
            S_DIV_RUN:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_DIV_SETUP;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pushed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pushed_reg <= pushed_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

[design/swbs_datapath.sv]
module swbs_datapath #(
    parameter int MAX_WINDOW = swbs_pkg::MAX_WINDOW_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swbs_pkg::in_item_t     in_data,
    output swbs_pkg::out_item_t    out_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  logic [6:0]             window_size,
    input  logic [15:0]            target_scale,
    input  logic [15:0]            max_scale,
    input  swbs_pkg::ctrl_cmd_t    cmd,
    output swbs_pkg::ctrl_status_t status
);

    localparam int IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNTW = $clog2(MAX_WINDOW + 1);
    localparam int S16W = 16 + $clog2(MAX_WINDOW);
    localparam int S32W = 32 + $clog2(MAX_WINDOW);
    localparam int DW   = S32W + 10;

    typedef enum logic [2:0] {
        OP_AVG_SIZE  = 3'd0,
        OP_FILL      = 3'd1,
        OP_AVG_BYTES = 3'd2,
        OP_RATIO     = 3'd3,
        OP_PRESSURE  = 3'd4,
        OP_END       = 3'd5
    } op_t;

    logic [15:0]     new_size_reg, new_size_next;
    logic [15:0]     new_depth_reg, new_depth_next;
    logic [31:0]     new_bytes_reg, new_bytes_next;
    logic [31:0]     new_delta_reg, new_delta_next;
    logic [IW-1:0]   oldest_reg, oldest_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [S16W-1:0] size_sum_reg, size_sum_next;
    logic [S32W-1:0] bytes_sum_reg, bytes_sum_next;
    logic [S32W-1:0] read_sum_reg, read_sum_next;
    logic [63:0]     last_reads_reg, last_reads_next;
    logic [15:0]     held_avg_size_reg, held_avg_size_next;
    logic [9:0]      held_fill_reg, held_fill_next;
    logic [31:0]     held_avg_bytes_reg, held_avg_bytes_next;
    logic [15:0]     held_pressure_reg, held_pressure_next;
    logic [9:0]      ratio_reg, ratio_next;
    logic [15:0]     peak_reg, peak_next;
    logic [IW-1:0]   scan_addr_reg, scan_addr_next;
    logic [CNTW-1:0] scan_left_reg, scan_left_next;
    logic            scan_pend_reg, scan_pend_next;
    op_t             op_reg, op_next;
    swbs_pkg::out_item_t out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic [63:0]     reads_diff;
    logic [CNTW:0]   slot_sum;
    logic [IW-1:0]   slot;
    logic [IW-1:0]   raddr;
    logic [CNTW-1:0] limit;
    logic [15:0]     scale;
    logic [S32W:0]   total;
    logic [15:0]     rd_size;
    logic [15:0]     rd_depth;
    logic [31:0]     rd_bytes;
    logic [31:0]     rd_delta;
    logic [DW-1:0]   div_num;
    logic [DW-1:0]   div_den;
    logic [DW-1:0]   div_quo;
    logic [DW-1:0]   avg_x;
    logic [DW-1:0]   reads_x;
    logic [DW-1:0]   cnt_x;
    logic            div_busy;
    logic            div_done;
    logic            op_needed;
    logic [63:0]     cnt_ext;
    logic [63:0]     reads_ext;
    logic [63:0]     size_ext;
    logic [63:0]     quo_ext;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        return (int'(idx) == MAX_WINDOW - 1) ? '0 : idx + IW'(1);
    endfunction

    assign reads_diff = in_data.total_reads - last_reads_reg;
    assign slot_sum   = (CNTW+1)'(oldest_reg) + (CNTW+1)'(cnt_reg);
    assign slot       = (slot_sum >= (CNTW+1)'(MAX_WINDOW))
                        ? IW'(slot_sum - (CNTW+1)'(MAX_WINDOW)) : IW'(slot_sum);
    assign raddr      = cmd.scan_step ? scan_addr_reg : oldest_reg;
    assign limit      = (int'(window_size) > MAX_WINDOW) ? CNTW'(MAX_WINDOW)
                                                         : CNTW'(window_size);
    assign scale      = (target_scale != 16'd0) ? target_scale
                        : ((max_scale != 16'd0) ? max_scale : 16'd1);
    assign total      = (S32W+1)'(read_sum_reg) + (S32W+1)'(size_sum_reg);

    assign avg_x   = DW'(held_avg_size_reg);
    assign reads_x = DW'(read_sum_reg);
    assign cnt_x   = DW'(cnt_reg);

    swbs_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW)) u_size_ram (
        .clk(clk), .we(cmd.push), .waddr(slot), .wdata(new_size_reg),
        .raddr(raddr), .rdata(rd_size)
    );
    swbs_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW)) u_depth_ram (
        .clk(clk), .we(cmd.push), .waddr(slot), .wdata(new_depth_reg),
        .raddr(raddr), .rdata(rd_depth)
    );
    swbs_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW)) u_bytes_ram (
        .clk(clk), .we(cmd.push), .waddr(slot), .wdata(new_bytes_reg),
        .raddr(raddr), .rdata(rd_bytes)
    );
    swbs_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW)) u_delta_ram (
        .clk(clk), .we(cmd.push), .waddr(slot), .wdata(new_delta_reg),
        .raddr(raddr), .rdata(rd_delta)
    );

    always_comb
    begin
        div_num   = DW'(size_sum_reg);
        div_den   = cnt_x;
        op_needed = 1'b0;
        case (op_reg)
            OP_AVG_SIZE:
            begin
                div_num   = DW'(size_sum_reg);
                div_den   = cnt_x;
                op_needed = (cnt_reg != '0);
            end
            OP_FILL:
            begin
                div_num   = (avg_x << 10) - (avg_x << 4) - (avg_x << 3);
                div_den   = DW'(scale);
                op_needed = (cnt_reg != '0);
            end
            OP_AVG_BYTES:
            begin
                div_num   = DW'(bytes_sum_reg);
                div_den   = cnt_x;
                op_needed = (cnt_reg != '0);
            end
            OP_RATIO:
            begin
                div_num   = (reads_x << 10) - (reads_x << 4) - (reads_x << 3);
                div_den   = DW'(total);
                op_needed = (total != '0);
            end
            OP_PRESSURE:
            begin
                div_num   = (cnt_x << 10) - (cnt_x << 4) - (cnt_x << 3)
                            + DW'(size_sum_reg) - DW'(1);
                div_den   = DW'(size_sum_reg);
                op_needed = (cnt_reg != '0) && (size_sum_reg != '0);
            end
            default:
            begin
                op_needed = 1'b0;
            end
        endcase
    end

    swbs_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .done(div_done), .quo(div_quo)
    );

    assign cnt_ext   = 64'(cnt_reg);
    assign reads_ext = 64'(read_sum_reg);
    assign size_ext  = 64'(size_sum_reg);
    assign quo_ext   = 64'(div_quo);

    always_comb
    begin
        new_size_next       = new_size_reg;
        new_depth_next      = new_depth_reg;
        new_bytes_next      = new_bytes_reg;
        new_delta_next      = new_delta_reg;
        oldest_next         = oldest_reg;
        cnt_next            = cnt_reg;
        size_sum_next       = size_sum_reg;
        bytes_sum_next      = bytes_sum_reg;
        read_sum_next       = read_sum_reg;
        last_reads_next     = last_reads_reg;
        held_avg_size_next  = held_avg_size_reg;
        held_fill_next      = held_fill_reg;
        held_avg_bytes_next = held_avg_bytes_reg;
        held_pressure_next  = held_pressure_reg;
        ratio_next          = ratio_reg;
        peak_next           = peak_reg;
        scan_addr_next      = scan_addr_reg;
        scan_left_next      = scan_left_reg;
        scan_pend_next      = scan_pend_reg;
        op_next             = op_reg;
        out_next            = out_reg;
        out_valid_next      = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            new_size_next   = in_data.wr_count;
            new_depth_next  = in_data.q_depth;
            new_bytes_next  = in_data.batch_log_bytes;
            if (in_data.total_reads < last_reads_reg)
            begin
                new_delta_next = '0;
            end
            else
            begin
                new_delta_next = (reads_diff[63:32] != '0) ? '1 : reads_diff[31:0];
            end
            last_reads_next = in_data.total_reads;
            ratio_next      = '0;
            op_next         = OP_AVG_SIZE;
        end

        if (cmd.drop_sub)
        begin
            size_sum_next  = size_sum_reg - S16W'(rd_size);
            bytes_sum_next = bytes_sum_reg - S32W'(rd_bytes);
            read_sum_next  = read_sum_reg - S32W'(rd_delta);
            oldest_next    = wrap_inc(oldest_reg);
            cnt_next       = cnt_reg - CNTW'(1);
        end

        if (cmd.push)
        begin
            size_sum_next  = size_sum_reg + S16W'(new_size_reg);
            bytes_sum_next = bytes_sum_reg + S32W'(new_bytes_reg);
            read_sum_next  = read_sum_reg + S32W'(new_delta_reg);
            cnt_next       = cnt_reg + CNTW'(1);
        end

        if (cmd.div_skip)
        begin
            op_next = op_t'(op_reg + 3'd1);
        end

        if (cmd.div_store)
        begin
            op_next = op_t'(op_reg + 3'd1);
            case (op_reg)
                OP_AVG_SIZE:
                begin
                    held_avg_size_next = (quo_ext > 64'd65535) ? '1 : div_quo[15:0];
                end
                OP_FILL:
                begin
                    held_fill_next = (quo_ext > 64'd1000) ? 10'd1000 : div_quo[9:0];
                end
                OP_AVG_BYTES:
                begin
                    held_avg_bytes_next = (quo_ext > 64'hFFFF_FFFF) ? '1 : div_quo[31:0];
                end
                OP_RATIO:
                begin
                    ratio_next = div_quo[9:0];
                end
                OP_PRESSURE:
                begin
                    held_pressure_next = (quo_ext > 64'd65535) ? '1 : div_quo[15:0];
                end
                default:
                begin
                    op_next = OP_END;
                end
            endcase
        end

        if (cmd.scan_init)
        begin
            scan_addr_next = oldest_reg;
            scan_left_next = cnt_reg;
            scan_pend_next = 1'b0;
            peak_next      = '0;
        end

        if (cmd.scan_step)
        begin
            if (scan_pend_reg && (rd_depth > peak_reg))
            begin
                peak_next = rd_depth;
            end
            if (scan_left_reg != '0)
            begin
                scan_addr_next = wrap_inc(scan_addr_reg);
                scan_left_next = scan_left_reg - CNTW'(1);
                scan_pend_next = 1'b1;
            end
            else
            begin
                scan_pend_next = 1'b0;
            end
        end

        if (cmd.out_load)
        begin
            out_next.window_count           = (cnt_ext > 64'd127) ? '1 : cnt_ext[6:0];
            out_next.avg_size               = held_avg_size_reg;
            out_next.batch_fill_per_1000    = held_fill_reg;
            out_next.avg_log_bytes          = held_avg_bytes_reg;
            out_next.window_reads           = (reads_ext > 64'h3F_FFFF_FFFF)
                                              ? '1 : reads_ext[37:0];
            out_next.window_writes          = (size_ext > 64'h3F_FFFF)
                                              ? '1 : size_ext[21:0];
            out_next.read_ratio_per_1000    = ratio_reg;
            out_next.peak_depth             = peak_reg;
            out_next.sync_pressure_per_1000 = held_pressure_reg;
            out_valid_next                  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg         <= '0;
            cnt_reg            <= '0;
            size_sum_reg       <= '0;
            bytes_sum_reg      <= '0;
            read_sum_reg       <= '0;
            last_reads_reg     <= '0;
            held_avg_size_reg  <= '0;
            held_fill_reg      <= '0;
            held_avg_bytes_reg <= '0;
            held_pressure_reg  <= '0;
            ratio_reg          <= '0;
            peak_reg           <= '0;
            scan_addr_reg      <= '0;
            scan_left_reg      <= '0;
            scan_pend_reg      <= 1'b0;
            op_reg             <= OP_END;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            oldest_reg         <= oldest_next;
            cnt_reg            <= cnt_next;
            size_sum_reg       <= size_sum_next;
            bytes_sum_reg      <= bytes_sum_next;
            read_sum_reg       <= read_sum_next;
            last_reads_reg     <= last_reads_next;
            held_avg_size_reg  <= held_avg_size_next;
            held_fill_reg      <= held_fill_next;
            held_avg_bytes_reg <= held_avg_bytes_next;
            held_pressure_reg  <= held_pressure_next;
            ratio_reg          <= ratio_next;
            peak_reg           <= peak_next;
            scan_addr_reg      <= scan_addr_next;
            scan_left_reg      <= scan_left_next;
            scan_pend_reg      <= scan_pend_next;
            op_reg             <= op_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_size_reg  <= new_size_next;
        new_depth_reg <= new_depth_next;
        new_bytes_reg <= new_bytes_next;
        new_delta_reg <= new_delta_next;
        out_reg       <= out_next;
    end

    assign status.count_full = (cnt_reg >= CNTW'(MAX_WINDOW));
    assign status.over_limit = (cnt_reg > limit);
    assign status.op_end     = (op_reg == OP_END);
    assign status.op_needed  = op_needed;
    assign status.div_done   = div_done;
    assign status.scan_done  = (scan_left_reg == '0) && !scan_pend_reg;
    assign status.out_busy   = out_valid_reg;

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_WINDOW))
        else $error("window count above ring depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (cnt_reg < CNTW'(MAX_WINDOW)))
        else $error("push into a full ring");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load lost");

endmodule

[design/sliding_window_batch_stats_core.sv]
// Each request is taken in and stored (the oldest entry is dropped first when the ring is full),
// entries beyond the window size are trimmed, each needed division runs on the shared
// bit-serial divider (skipped when not needed), then the peak scan and the result load follow.
// The core handles one item at a time; the next request is taken once the previous result is
// loaded into the output register.
// Reset (rst_n, asynchronous, active low) empties the window and restores register defaults.
module sliding_window_batch_stats_core #(
    parameter int MAX_WINDOW = swbs_pkg::MAX_WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swbs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output swbs_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [6:0]  window_size_reg;
    logic [15:0] target_batch_reg;
    logic [15:0] max_batch_reg;
    logic        cfg_wr;

    swbs_pkg::ctrl_cmd_t    cmd;
    swbs_pkg::ctrl_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= swbs_pkg::WINDOW_SIZE_RST;
            target_batch_reg <= swbs_pkg::TARGET_BATCH_RST;
            max_batch_reg    <= swbs_pkg::MAX_BATCH_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                swbs_pkg::REG_WINDOW_SIZE:  window_size_reg  <= pwdata[6:0];
                swbs_pkg::REG_TARGET_BATCH: target_batch_reg <= pwdata[15:0];
                swbs_pkg::REG_MAX_BATCH:    max_batch_reg    <= pwdata[15:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            swbs_pkg::REG_WINDOW_SIZE:  prdata = 32'(window_size_reg);
            swbs_pkg::REG_TARGET_BATCH: prdata = 32'(target_batch_reg);
            swbs_pkg::REG_MAX_BATCH:    prdata = 32'(max_batch_reg);
            default:                    prdata = '0;
        endcase
    end

    swbs_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status(status),
        .cmd(cmd)
    );

    swbs_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .in_data(in_data),
        .out_data(out_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .window_size(window_size_reg),
        .target_scale(target_batch_reg),
        .max_scale(max_batch_reg),
        .cmd(cmd),
        .status(status)
    );

endmodule

[tb/swbs_checker.sv]
`timescale 1ns / 100ps

module swbs_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  swbs_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  swbs_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  errors,
    output int                  pending
);

    localparam int RING   = 64;
    localparam int QDEPTH = 8;

    logic [15:0] size_hist  [RING];
    logic [15:0] depth_hist [RING];
    logic [31:0] bytes_hist [RING];
    logic [31:0] delta_hist [RING];
    logic [5:0]  head;
    logic [6:0]  fill_cnt;
    logic [63:0] sum_size, sum_bytes, sum_reads, prev_reads;
    logic [15:0] keep_avg_size, keep_pressure;
    logic [9:0]  keep_fill;
    logic [31:0] keep_avg_bytes;
    logic [6:0]  cfg_window;
    logic [15:0] cfg_target, cfg_max;

    swbs_pkg::out_item_t exp_buf [QDEPTH];
    int                  wr_ptr;
    int                  rd_ptr;

    assign pending = wr_ptr - rd_ptr;

    task automatic retire_oldest();
        sum_size  = sum_size - size_hist[head];
        sum_bytes = sum_bytes - bytes_hist[head];
        sum_reads = sum_reads - delta_hist[head];
        head      = head + 6'd1;
        fill_cnt  = fill_cnt - 7'd1;
    endtask

    task automatic window_stats(input swbs_pkg::in_item_t req,
                                output swbs_pkg::out_item_t res);
        logic [63:0] delta, lim, scale, avg, fillv, total, pres;
        logic [5:0]  slot;
        logic [15:0] peak;
        begin
            delta = (req.total_reads >= prev_reads) ? req.total_reads - prev_reads : 64'd0;
            if (delta > 64'hFFFF_FFFF)
                delta = 64'hFFFF_FFFF;
            prev_reads = req.total_reads;
            lim = (cfg_window > RING) ? RING : cfg_window;
            if (fill_cnt >= RING)
                retire_oldest();
            slot = head + fill_cnt[5:0];
            size_hist[slot]  = req.wr_count;
            depth_hist[slot] = req.q_depth;
            bytes_hist[slot] = req.batch_log_bytes;
            delta_hist[slot] = delta[31:0];
            fill_cnt  = fill_cnt + 7'd1;
            sum_size  = sum_size + req.wr_count;
            sum_bytes = sum_bytes + req.batch_log_bytes;
            sum_reads = sum_reads + delta;
            while (fill_cnt > lim)
                retire_oldest();
            if (fill_cnt > 0)
            begin
                scale = (cfg_target > 0) ? cfg_target : cfg_max;
                if (scale == 0)
                    scale = 1;
                avg = sum_size / fill_cnt;
                keep_avg_size = (avg > 64'hFFFF) ? 16'hFFFF : avg[15:0];
                fillv = (avg * 1000) / scale;
                keep_fill = (fillv > 1000) ? 10'd1000 : fillv[9:0];
                avg = sum_bytes / fill_cnt;
                keep_avg_bytes = (avg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : avg[31:0];
            end
            total = sum_reads + sum_size;
            peak = 16'd0;
            for (int k = 0; k < fill_cnt; k++)
                if (depth_hist[6'(head + k)] > peak)
                    peak = depth_hist[6'(head + k)];
            if (fill_cnt > 0 && sum_size > 0)
            begin
                pres = (fill_cnt * 64'd1000 + sum_size - 1) / sum_size;
                keep_pressure = (pres > 64'hFFFF) ? 16'hFFFF : pres[15:0];
            end
            res.window_count           = fill_cnt;
            res.avg_size               = keep_avg_size;
            res.batch_fill_per_1000    = keep_fill;
            res.avg_log_bytes          = keep_avg_bytes;
            res.window_reads           = (sum_reads > 64'h3F_FFFF_FFFF) ? 38'h3F_FFFF_FFFF
                                                                        : sum_reads[37:0];
            res.window_writes          = (sum_size > 64'h3F_FFFF) ? 22'h3F_FFFF : sum_size[21:0];
            res.read_ratio_per_1000    = (total == 0) ? 10'd0 : 10'((sum_reads * 1000) / total);
            res.peak_depth             = peak;
            res.sync_pressure_per_1000 = keep_pressure;
        end
    endtask

    task automatic check_field(input string fname, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            if (errors < 10)
                $display("mismatch %s: expected %0d got %0d at %0t", fname, exp_v, act_v,
                         $realtime);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        swbs_pkg::out_item_t want, got;
        if (!rst_n)
        begin
            head = '0; fill_cnt = '0;
            sum_size = '0; sum_bytes = '0; sum_reads = '0; prev_reads = '0;
            keep_avg_size = '0; keep_pressure = '0; keep_fill = '0; keep_avg_bytes = '0;
            cfg_window = swbs_pkg::WINDOW_SIZE_RST;
            cfg_target = swbs_pkg::TARGET_BATCH_RST;
            cfg_max    = swbs_pkg::MAX_BATCH_RST;
            wr_ptr = 0;
            rd_ptr = 0;
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    swbs_pkg::REG_WINDOW_SIZE:  cfg_window = pwdata[6:0];
                    swbs_pkg::REG_TARGET_BATCH: cfg_target = pwdata[15:0];
                    swbs_pkg::REG_MAX_BATCH:    cfg_max    = pwdata[15:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (wr_ptr == rd_ptr)
                begin
                    if (errors < 10)
                        $display("unexpected result at %0t", $realtime);
                    errors = errors + 1;
                end
                else
                begin
                    want = exp_buf[rd_ptr % QDEPTH];
                    rd_ptr = rd_ptr + 1;
                    check_field("window_count", want.window_count, got.window_count);
                    check_field("avg_size", want.avg_size, got.avg_size);
                    check_field("batch_fill_per_1000", want.batch_fill_per_1000,
                                got.batch_fill_per_1000);
                    check_field("avg_log_bytes", want.avg_log_bytes, got.avg_log_bytes);
                    check_field("window_reads", want.window_reads, got.window_reads);
                    check_field("window_writes", want.window_writes, got.window_writes);
                    check_field("read_ratio_per_1000", want.read_ratio_per_1000,
                                got.read_ratio_per_1000);
                    check_field("peak_depth", want.peak_depth, got.peak_depth);
                    check_field("sync_pressure_per_1000", want.sync_pressure_per_1000,
                                got.sync_pressure_per_1000);
                end
            end
            if (in_valid && !in_stall)
            begin
                window_stats(in_data, want);
                if (wr_ptr - rd_ptr >= QDEPTH)
                begin
                    if (errors < 10)
                        $display("too many results outstanding at %0t", $realtime);
                    errors = errors + 1;
                end
                else
                begin
                    exp_buf[wr_ptr % QDEPTH] = want;
                    wr_ptr = wr_ptr + 1;
                end
            end
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 2000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    swbs_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    swbs_pkg::out_item_t out_data;
    logic                psel, penable, pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    int                  errors;
    int                  pending;

    int          tx_pct;
    int          rx_pct;
    int          hold_seq;
    int          hold_seen;
    int          hold_left;
    int          cycles = 0;
    logic [63:0] read_ctr;

    sliding_window_batch_stats_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    swbs_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sliding_window_batch_stats_core verification failed");
            $finish;
        end
    end

    // hold off the receiver for a long stretch when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= 3000;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_pct);
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(input swbs_pkg::in_item_t req);
        while ($urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [15:0] bs, input logic [15:0] qd,
                               input logic [31:0] lb, input logic [63:0] rd);
        swbs_pkg::in_item_t req;
        req.wr_count        = bs;
        req.q_depth         = qd;
        req.batch_log_bytes = lb;
        req.total_reads     = rd;
        send_request(req);
    endtask

    task automatic random_request();
        int          pick;
        logic [15:0] bs;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            read_ctr = read_ctr + $urandom_range(0, 5000);
        else if (pick < 88)
            read_ctr = read_ctr - $urandom_range(1, 3000);
        else if (pick < 94)
            read_ctr = {$urandom, $urandom};
        else
            read_ctr = read_ctr + {$urandom_range(0, 3), $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 10)
            bs = 16'd0;
        else if (pick < 70)
            bs = 16'($urandom_range(1, 200));
        else
            bs = 16'($urandom);
        send_fields(bs, 16'($urandom), $urandom, read_ctr);
    endtask

    logic [6:0]  win_set [8] = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd3, 7'd64, 7'd100, 7'd8};
    logic [15:0] tgt_set [8] = '{16'd0, 16'd100, 16'd0, 16'd65535, 16'd0, 16'd500, 16'd0,
                                 16'd40};
    logic [15:0] max_set [8] = '{16'd64, 16'd64, 16'd0, 16'd0, 16'd65535, 16'd1, 16'd1000,
                                 16'd64};

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        tx_pct   = 12;
        rx_pct   = 73;
        hold_seq = 0;
        read_ctr = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(16'd0, 16'd0, 32'd0, 64'd0);
        send_fields(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'd1000);
        send_fields(16'd0, 16'd5, 32'd0, 64'd10);
        send_fields(16'd1, 16'd0, 32'd1, 64'd20);
        send_fields(16'd7, 16'd9, 32'd100, 64'd5);
        send_fields(16'd7, 16'd9, 32'd100, 64'hFFFF_FFFF_FFFF_FFFF);
        send_fields(16'd3, 16'd1, 32'd7, 64'd0);
        send_fields(16'd3, 16'd1, 32'd7, 64'h0000_0001_0000_0000);
        send_fields(16'd3, 16'd1, 32'd7, 64'h0000_0001_FFFF_FFFF);
        send_fields(16'd500, 16'd3000, 32'hFFFF_FFFF, 64'h0000_0002_0000_0000);
        drain();
        reg_write(swbs_pkg::REG_WINDOW_SIZE, 32'd0);
        send_fields(16'd10, 16'd10, 32'd10, 64'h0000_0002_0000_0010);
        send_fields(16'd0, 16'd0, 32'd0, 64'h0000_0002_0000_0020);
        drain();
        reg_write(swbs_pkg::REG_WINDOW_SIZE, 32'd64);
        reg_write(swbs_pkg::REG_MAX_BATCH, 32'd0);
        reg_write(2'd3, 32'hFFFF_FFFF);
        repeat (70) send_fields(16'hFFFF, 16'($urandom), 32'hFFFF_FFFF, 64'd0);
        drain();
        reg_write(swbs_pkg::REG_WINDOW_SIZE, 32'd2);
        send_fields(16'd0, 16'd1, 32'd1, {$urandom, $urandom});
        send_fields(16'd0, 16'd2, 32'd2, 64'd0);
        read_ctr = 64'd0;

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            if (ph == 3)
            begin
                tx_pct = 73;
                rx_pct = 12;
            end
            else if (ph == 6)
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
            reg_write(swbs_pkg::REG_WINDOW_SIZE, {25'd0, win_set[ph]});
            reg_write(swbs_pkg::REG_TARGET_BATCH, {16'd0, tgt_set[ph]});
            reg_write(swbs_pkg::REG_MAX_BATCH, {16'd0, max_set[ph]});
            if (ph == 5)
                hold_seq = hold_seq + 1;
            repeat (40) random_request();
        end

        drain();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("sliding_window_batch_stats_core verification clean");
        else
            $display("sliding_window_batch_stats_core verification failed");
        $finish;
    end

endmodule
